// ===== rtl/core/ile_pkg.sv =====
// Shared types and constants for the indexed list engine.
// No dependencies; every other file of the block except ile_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 11;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_LENGTH = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_MOVE   = 3'd4,
    OP_MAX    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ANS_COUNT = 2'd0,
    ANS_NEG1  = 2'd1,
    ANS_BEST  = 2'd2
  } ans_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic     start;
    logic     issue;
    logic     final_wr;
    logic     out_load;
    ans_sel_t ans_sel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  req_op;
    op_t  cur_op;
    logic pos_lt;
    logic pos_le;
    logic full;
    logic empty;
    logic at_end;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ile_if.sv =====
// Stream interfaces for the request and answer channels.
// Depends on ile_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ile_req_if;
  import ile_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, operation, position, item_value, input ready);
  modport sink   (input valid, operation, position, item_value, output ready);
endinterface

interface ile_rsp_if;
  import ile_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] answer;

  modport source (output valid, answer, input ready);
  modport sink   (input valid, answer, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/indexed_list_engine_unit.sv =====
// Indexed list engine top level: joins controller and datapath to the channels.
// Depends on ile_pkg, ile_if, ile_ctrl, ile_dpath.
//
// Usage:
//   req (sink): operation, position, item_value. A word is taken when valid
//   and ready are high at a clock edge; ready is high only while the engine
//   is idle, so one request is worked on at a time.
//   rsp (source): answer, for length, read and maximum requests only.
//   Length requests, failed reads and maxima of an empty list answer
//   without a scan; a read at a valid position scans up to that position,
//   and a maximum scans the whole list, before answering.
//   Inserts, removes and moves shift the entries from the position onward
//   through the sequence RAM; inserts and moves end with a final write.
//   An insert at the end only writes; out-of-range requests are dropped.
//   The RAM gives one read and one write per cycle, so shifted and scanned
//   entries pass through the sequence RAM one at a time.
//   Reset (rst, synchronous) empties the list; RAM contents are not cleared.
//   A stalled receiver holds the answer in the output register; the engine
//   finishes the next request but waits with its answer until the slot frees.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine_unit (
  input wire logic clk,
  input wire logic rst,
  ile_req_if.sink  req,
  ile_rsp_if.source rsp
);
  import ile_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ile_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .operation  (req.operation),
    .position   (req.position),
    .item_value (req.item_value),
    .cmd        (cmd),
    .stat       (stat),
    .answer     (rsp.answer)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ile_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ile_ctrl.sv =====
// Controller FSM of the indexed list engine: sequences scans, final writes
// and answer words. Depends on ile_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ile_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire ile_pkg::stat_t stat,
  output ile_pkg::cmd_t      cmd
);
  import ile_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t   state, state_next;
  ans_sel_t sel, sel_next;
  logic     out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    sel_next       = sel;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.ans_sel    = sel;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          case (stat.req_op) inside
            OP_LENGTH: begin
              sel_next   = ANS_COUNT;
              state_next = ST_RESP;
            end
            OP_INSERT: begin
              if (!stat.full && stat.pos_le) begin
                state_next = stat.pos_lt ? ST_SCAN : ST_FINAL;
              end
            end
            OP_READ: begin
              if (stat.pos_lt) begin
                state_next = ST_SCAN;
              end else begin
                sel_next   = ANS_NEG1;
                state_next = ST_RESP;
              end
            end
            OP_REMOVE, OP_MOVE: begin
              if (stat.pos_lt) begin
                state_next = ST_SCAN;
              end
            end
            OP_MAX: begin
              if (!stat.empty) begin
                state_next = ST_SCAN;
              end else begin
                sel_next   = ANS_NEG1;
                state_next = ST_RESP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.at_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read word is consumed by the datapath this cycle
        case (stat.cur_op) inside
          OP_READ, OP_MAX: begin
            sel_next   = ANS_BEST;
            state_next = ST_RESP;
          end
          default: state_next = ST_FINAL;
        endcase
      end
      ST_FINAL: begin
        cmd.final_wr = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_RESP: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= ANS_COUNT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ile_dpath.sv =====
// Datapath of the indexed list engine: sequence RAM, count, scan pointer,
// shift write-back, maximum tracking and answer register. Depends on ile_pkg, ile_ram.
`timescale 1ns / 1ps
`default_nettype none

module ile_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [ile_pkg::OP_W-1:0]          operation,
  input  wire logic [ile_pkg::POS_W-1:0]         position,
  input  wire logic signed [ile_pkg::DATA_W-1:0] item_value,
  input  wire ile_pkg::cmd_t                     cmd,
  output ile_pkg::stat_t                         stat,
  output logic signed [ile_pkg::DATA_W-1:0]      answer
);
  import ile_pkg::*;

  op_t               op_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] p;
  logic [ADDR_W-1:0] la;
  logic              lv;
  logic              first;
  logic [DATA_W-1:0] hold;
  logic [DATA_W-1:0] best;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;
  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] pos_addr;
  logic [ADDR_W-1:0] p_init;
  logic              scan_up;

  assign cnt_m1   = count - CNT_W'(1);
  assign pos_addr = ADDR_W'(pos_q);
  assign scan_up  = (op_q != OP_INSERT);

  ile_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (p),
    .rdata (rdata)
  );

  // status
  always_comb begin
    stat        = '0;
    stat.req_op = op_t'(operation);
    stat.cur_op = op_q;
    stat.pos_lt = CMP_W'(position) < CMP_W'(count);
    stat.pos_le = CMP_W'(position) <= CMP_W'(count);
    stat.full   = (count == CNT_W'(CAPACITY));
    stat.empty  = (count == '0);
    case (op_q) inside
      OP_INSERT, OP_READ: stat.at_end = (p == pos_addr);
      default:            stat.at_end = (p == cnt_m1[ADDR_W-1:0]);
    endcase
  end

  always_comb begin
    case (op_t'(operation)) inside
      OP_INSERT: p_init = cnt_m1[ADDR_W-1:0];
      OP_MAX:    p_init = '0;
      default:   p_init = ADDR_W'(position);
    endcase
  end

  // write port: shift write-back while scanning, one final write at the end of an insert or move
  always_comb begin
    we    = 1'b0;
    waddr = la;
    wdata = rdata;
    if (lv) begin
      case (op_q) inside
        OP_INSERT: begin
          we    = 1'b1;
          waddr = la + ADDR_W'(1);
        end
        OP_REMOVE, OP_MOVE: begin
          // first word read is the removed entry itself
          if (!first) begin
            we    = 1'b1;
            waddr = la - ADDR_W'(1);
          end
        end
        default: ;
      endcase
    end
    if (cmd.final_wr) begin
      case (op_q) inside
        OP_INSERT: begin
          we    = 1'b1;
          waddr = pos_addr;
          wdata = val_q;
        end
        OP_MOVE: begin
          we    = 1'b1;
          waddr = cnt_m1[ADDR_W-1:0];
          wdata = hold;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q  <= OP_LENGTH;
      count <= '0;
      lv    <= 1'b0;
      first <= 1'b0;
    end else begin
      lv <= cmd.issue;
      if (cmd.start) begin
        op_q  <= op_t'(operation);
        first <= 1'b1;
      end else if (lv) begin
        first <= 1'b0;
      end
      if (cmd.final_wr) begin
        case (op_q)
          OP_INSERT: count <= count + CNT_W'(1);
          OP_REMOVE: count <= cnt_m1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos_q <= position;
      val_q <= item_value;
      p     <= p_init;
    end else if (cmd.issue) begin
      p <= scan_up ? p + ADDR_W'(1) : p - ADDR_W'(1);
    end
    if (cmd.issue) begin
      la <= p;
    end
    if (lv && first) begin
      hold <= rdata;
    end
    if (lv && (op_q == OP_READ || op_q == OP_MAX)) begin
      if (first || ($signed(rdata) > $signed(best))) begin
        best <= rdata;
      end
    end
    if (cmd.out_load) begin
      case (cmd.ans_sel)
        ANS_COUNT: answer <= {{(DATA_W-CNT_W){1'b0}}, count};
        ANS_NEG1:  answer <= '1;
        ANS_BEST:  answer <= best;
        default:   answer <= '1;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ile_checker.sv =====
// Port-level checks for the indexed list engine, bound to the top level.
// Depends on ile_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ile_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [ile_pkg::OP_W-1:0]   in_op,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [ile_pkg::DATA_W-1:0] answer
);
  import ile_pkg::*;

  // after reset the engine is idle with no answer pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("not idle after reset");

  // a length request on a free output passes through the response state, then its word is valid
  a_length_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_op == OP_LENGTH && !out_valid) |-> ##2 out_valid)
    else $error("length answer late");

  // a request that answers keeps the engine busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_op == OP_LENGTH || in_op == OP_READ || in_op == OP_MAX))
    |=> !in_ready)
    else $error("ready while answering");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("answer dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(answer))
    else $error("answer changed while stalled");

endmodule

bind indexed_list_engine_unit ile_checker u_ile_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .in_op     (req.operation),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .answer    (rsp.answer)
);

`default_nettype wire
